FILE: rtl/core/cdk_pkg.sv
package cdk_pkg;

   localparam int NUM_SUITS_DEF  = 4;
   localparam int NUM_VALUES_DEF = 13;

   localparam int OPCODE_W = 2;
   localparam int RAND_W   = 16;
   localparam int VALUE_W  = 4;
   localparam int SUIT_W   = 3;

   localparam logic [OPCODE_W-1:0] OP_RESET   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SHUFFLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DRAW    = 2'd2;

   typedef struct packed {
      logic [SUIT_W-1:0]  suit;
      logic [VALUE_W-1:0] value;
   } card_type;

   localparam int CARD_W = $bits(card_type);

endpackage

FILE: rtl/core/cdk_ram.sv
module cdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cdk_mod.sv
module cdk_mod #(
   parameter int DIV_W = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cdk_pkg::RAND_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          remainder
);

   import cdk_pkg::*;

   localparam int CNT_W = $clog2(RAND_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RAND_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W:0]      trial;
   logic [DIV_W:0]      dvs_ext;

   // One restoring step per cycle: shift in the next dividend bit and
   // subtract the divisor when it fits. The remainder stays below the divisor.
   always_comb begin
      trial   = {rem_ff, dvd_ff[RAND_W-1]};
      dvs_ext = {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         if (trial >= dvs_ext) begin
            rem_in = DIV_W'(trial - dvs_ext);
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/card_deck_shuffler.sv
// Card deck with a Fisher-Yates shuffle engine and a draw pointer.
// A request is taken on a rising edge where start is high and busy is low;
// req_opcode selects reload (0), one shuffle step (1) or a draw (2), and
// req_random_word feeds the shuffle step. Opcode 3 does nothing.
// Every request yields exactly one response, shown for one cycle with
// rsp_valid high. The receiver cannot stall; a response is never held.
// The response is registered. Reload, an unused opcode and a draw from an
// empty deck are answered straight from the request; a draw first reads
// the deck memory; a shuffle step first runs the 16-step modulo unit (one
// bit of the random word per cycle), then swaps the two entries through
// the single read port and single write port of the deck memory, reading
// both entries and then writing both.
// busy is high for the whole of a shuffle or draw; for the other
// operations busy stays low, so a new request can follow at once.
// The deck lives in a memory with one valid bit per entry; an entry that is
// not valid reads as its place in the ordered deck. Reset and a reload clear
// all valid bits along with both positions, so no clearing pass is
// needed.
module card_deck_shuffler #(
   parameter int NUM_SUITS  = cdk_pkg::NUM_SUITS_DEF,
   parameter int NUM_VALUES = cdk_pkg::NUM_VALUES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cdk_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [cdk_pkg::RAND_W-1:0]   req_random_word,
   output logic                         rsp_valid,
   output logic [cdk_pkg::VALUE_W-1:0]  rsp_card_value,
   output logic [cdk_pkg::SUIT_W-1:0]   rsp_card_suit,
   output logic                         rsp_deck_empty,
   output logic                         rsp_shuffle_done
);

   import cdk_pkg::*;

   localparam int DECK_N = NUM_SUITS * NUM_VALUES;
   localparam int POS_W  = $clog2(DECK_N + 1);
   localparam int ADDR_W = (DECK_N > 1) ? $clog2(DECK_N) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MOD  = 3'd1;
   localparam logic [2:0] ST_RDB  = 3'd2;
   localparam logic [2:0] ST_WRA  = 3'd3;
   localparam logic [2:0] ST_WRB  = 3'd4;
   localparam logic [2:0] ST_DRW  = 3'd5;

   card_type ord_tbl [DECK_N];

   for (genvar k = 0; k < DECK_N; k++) begin : g_ord
      localparam int SuitNum = k / NUM_VALUES + 1;
      localparam int ValNum  = k % NUM_VALUES + 1;
      assign ord_tbl[k] = '{suit: SUIT_W'(SuitNum), value: VALUE_W'(ValNum)};
   end

   logic [2:0]        st_ff, st_in;
   logic [POS_W-1:0]  shuf_pos_ff, shuf_pos_in;
   logic [POS_W-1:0]  draw_pos_ff, draw_pos_in;
   logic [POS_W-1:0]  other_ff, other_in;
   logic [DECK_N-1:0] vld_ff, vld_in;
   card_type          card_a_ff, card_a_in;
   logic              rd_vld_ff, rd_vld_in;
   card_type          rd_ord_ff, rd_ord_in;

   logic              rsp_valid_ff, rsp_valid_in;
   card_type          rsp_card_ff, rsp_card_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   card_type          ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CARD_W-1:0] ram_rd_data;
   card_type          rd_card;

   logic              mod_start;
   logic              mod_done;
   logic [POS_W-1:0]  mod_rem;
   logic [POS_W-1:0]  span;
   logic [POS_W:0]    pos_next2;
   logic              accept;

   assign accept    = start && (st_ff == ST_IDLE);
   assign span      = POS_W'(DECK_N) - shuf_pos_ff;
   assign pos_next2 = {1'b0, shuf_pos_ff} + (POS_W + 1)'(2);
   assign rd_card   = rd_vld_ff ? card_type'(ram_rd_data) : rd_ord_ff;

   always_comb begin
      st_in        = st_ff;
      shuf_pos_in  = shuf_pos_ff;
      draw_pos_in  = draw_pos_ff;
      other_in     = other_ff;
      vld_in       = vld_ff;
      card_a_in    = card_a_ff;
      rsp_valid_in = 1'b0;
      rsp_card_in  = '0;
      rsp_empty_in = 1'b0;
      rsp_done_in  = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = shuf_pos_ff[ADDR_W-1:0];
      ram_wr_data  = rd_card;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = shuf_pos_ff[ADDR_W-1:0];
      mod_start    = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_RESET: begin
                     vld_in       = '0;
                     shuf_pos_in  = '0;
                     draw_pos_in  = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SHUFFLE: begin
                     mod_start = 1'b1;
                     st_in     = ST_MOD;
                  end
                  OP_DRAW: begin
                     if (draw_pos_ff >= POS_W'(DECK_N)) begin
                        rsp_valid_in = 1'b1;
                        rsp_empty_in = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = draw_pos_ff[ADDR_W-1:0];
                        st_in       = ST_DRW;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               other_in  = shuf_pos_ff + mod_rem;
               ram_rd_en = 1'b1;
               st_in     = ST_RDB;
            end
         end
         ST_RDB: begin
            card_a_in   = rd_card;
            ram_rd_en   = 1'b1;
            ram_rd_addr = other_ff[ADDR_W-1:0];
            st_in       = ST_WRA;
         end
         ST_WRA: begin
            ram_wr_en = 1'b1;
            st_in     = ST_WRB;
         end
         ST_WRB: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = other_ff[ADDR_W-1:0];
            ram_wr_data  = card_a_ff;
            rsp_valid_in = 1'b1;
            if (pos_next2 >= (POS_W + 1)'(DECK_N)) begin
               shuf_pos_in = '0;
               rsp_done_in = 1'b1;
            end else begin
               shuf_pos_in = shuf_pos_ff + 1'b1;
            end
            st_in = ST_IDLE;
         end
         ST_DRW: begin
            rsp_valid_in = 1'b1;
            rsp_card_in  = rd_card;
            draw_pos_in  = draw_pos_ff + 1'b1;
            st_in        = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (ram_wr_en) begin
         vld_in[ram_wr_addr] = 1'b1;
      end
   end

   // The valid bit and the ordered card are sampled with the memory read so
   // that all three line up in the following cycle.
   always_comb begin
      rd_vld_in = rd_vld_ff;
      rd_ord_in = rd_ord_ff;
      if (ram_rd_en) begin
         rd_vld_in = vld_ff[ram_rd_addr];
         rd_ord_in = ord_tbl[ram_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         shuf_pos_ff  <= '0;
         draw_pos_ff  <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         shuf_pos_ff  <= shuf_pos_in;
         draw_pos_ff  <= draw_pos_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      other_ff     <= other_in;
      card_a_ff    <= card_a_in;
      rd_vld_ff    <= rd_vld_in;
      rd_ord_ff    <= rd_ord_in;
      rsp_card_ff  <= rsp_card_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_done_ff  <= rsp_done_in;
   end

   cdk_mod #(
      .DIV_W (POS_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_random_word),
      .divisor   (span),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   cdk_ram #(
      .WIDTH (CARD_W),
      .DEPTH (DECK_N)
   ) u_deck (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy             = (st_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_card_value   = rsp_card_ff.value;
   assign rsp_card_suit    = rsp_card_ff.suit;
   assign rsp_deck_empty   = rsp_empty_ff;
   assign rsp_shuffle_done = rsp_done_ff;

   a_draw_pos_range: assert property (@(posedge clock) disable iff (reset)
      draw_pos_ff <= POS_W'(DECK_N))
      else $error("draw position beyond deck size");

   a_shuf_pos_range: assert property (@(posedge clock) disable iff (reset)
      shuf_pos_ff < POS_W'(DECK_N))
      else $error("shuffle position beyond last entry");

   a_swap_in_deck: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RDB) |-> (other_ff < POS_W'(DECK_N) && other_ff >= shuf_pos_ff))
      else $error("swap partner outside the unshuffled part of the deck");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted request neither in progress nor answered");

   a_empty_is_joker: assert property (@(posedge clock) disable iff (reset)
      rsp_deck_empty |-> (rsp_card_value == '0 && rsp_card_suit == '0 && !rsp_shuffle_done))
      else $error("empty deck response carries a card");

endmodule
